FILE: hdl/stt_pkg.sv
package stt_pkg;

  localparam int MaxResults = 16;
  localparam int ResCountW  = 5;

  localparam logic [2:0] ACT_TICK      = 3'd0;
  localparam logic [2:0] ACT_INSERT    = 3'd1;
  localparam logic [2:0] ACT_DEL_TYPE  = 3'd2;
  localparam logic [2:0] ACT_DEL_MODE  = 3'd3;
  localparam logic [2:0] ACT_DEL_EVENT = 3'd4;
  localparam logic [2:0] ACT_RST_COUNT = 3'd5;
  localparam logic [2:0] ACT_QUERY     = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EXISTS   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [1:0] MODE_ONCE     = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;
  localparam logic [1:0] MODE_COND     = 2'd2;
  localparam logic [1:0] MODE_BAD      = 2'd3;

  typedef struct packed {
    logic [7:0]  evt;
    logic [1:0]  mode;
    logic [4:0]  typ;
    logic [3:0]  cls;
    logic [15:0] ival;
    logic [15:0] cnt;
  } entry_t;

endpackage

FILE: hdl/stt_ram.sv
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/software_timer_table.sv
// A valid item walks the active entries and then takes its final step; an invalid
//   one goes straight to the final step; an output stall holds both back.
// One item at a time: a new one is taken the cycle after its final result is
//   loaded; the walk reads one entry per cycle while the output does not stall.
// Reset: control state and the timer count clear at once; the entry memory
//   is not cleared, as entries at or above the timer count are never read.
module software_timer_table #(
  parameter int NUM_TIMERS  = 16,
  parameter int NUM_TYPES   = 16,
  parameter int NUM_CLASSES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // event_id[7:0], timer_mode[9:8], type_class[14:10], tick_class[18:15],
  // interval[34:19], start_count[50:35], cond_mask[66:51], zero fill above
  input  logic [71:0] s_tdata,
  // action[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], exists[3], fired_valid[4], fired_event[12:5], zero fill above
  output logic [15:0] m_tdata,
  output logic        m_tlast
);
  import stt_pkg::*;

  localparam int AW = $clog2(NUM_TIMERS);
  localparam int CW = $clog2(NUM_TIMERS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]  state;
  logic [CW-1:0] active_count;

  // command held for the walk
  logic [2:0]  act;
  logic [7:0]  ev;
  logic [1:0]  mode;
  logic [4:0]  typ;
  logic [3:0]  cls;
  logic [15:0] ival;
  logic [15:0] start;
  logic [15:0] mask;
  logic [2:0]  st;

  logic [CW-1:0] n;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] w_idx;
  logic [AW-1:0] proc_idx;
  logic          pend;
  logic          found;
  logic [ResCountW-1:0] k;
  logic          held_valid;
  logic [7:0]    held_event;

  logic          out_valid;
  logic [15:0]   out_data;
  logic          out_last;

  // memory port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  stt_ram #(.WIDTH($bits(entry_t)), .DEPTH(NUM_TIMERS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // input fields
  logic [7:0]  in_ev;
  logic [1:0]  in_mode;
  logic [4:0]  in_typ;
  logic [3:0]  in_cls;
  logic [15:0] in_ival;
  logic [15:0] in_start;
  logic        in_bad;

  assign in_ev    = s_tdata[7:0];
  assign in_mode  = s_tdata[9:8];
  assign in_typ   = s_tdata[14:10];
  assign in_cls   = s_tdata[18:15];
  assign in_ival  = s_tdata[34:19];
  assign in_start = s_tdata[50:35];

  always_comb begin
    case (s_tuser)
      ACT_TICK:      in_bad = 32'(in_cls) >= NUM_CLASSES;
      ACT_INSERT:    in_bad = (32'(in_typ) >= NUM_TYPES) || (in_mode == MODE_BAD) ||
                              (in_ev == 8'd0) || (in_ival == 16'd0) ||
                              (in_start > in_ival) || (32'(in_cls) >= NUM_CLASSES);
      ACT_DEL_TYPE:  in_bad = 32'(in_typ) >= NUM_TYPES;
      ACT_DEL_MODE:  in_bad = in_mode == MODE_BAD;
      ACT_DEL_EVENT: in_bad = in_ev == 8'd0;
      ACT_RST_COUNT: in_bad = 1'b0;
      ACT_QUERY:     in_bad = 1'b0;
      default:       in_bad = 1'b1;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  // hold the walk and the final step while a finished result waits on the output
  logic stall;
  logic out_load;
  logic [15:0] out_load_data;
  logic out_load_last;
  assign stall = out_valid && !m_tready;

  // per entry processing
  entry_t  e_new;
  logic    e_match;
  logic    e_expired;
  logic    e_remove;
  logic    e_hit;
  logic    e_fire;
  logic    compacting;
  logic [15:0] cnt_inc;
  logic    mbit;
  logic    walk_done;
  logic    walk_step;
  logic    fin_step;
  logic    ins_ok;
  logic [2:0] fin_status;

  assign compacting = (act == ACT_TICK) || (act == ACT_DEL_TYPE) ||
                      (act == ACT_DEL_MODE) || (act == ACT_DEL_EVENT);
  assign walk_done  = !pend && (rd_idx == n);
  assign walk_step  = (state == S_WALK) && !stall && !walk_done;
  assign fin_step   = (state == S_FIN) && !stall;

  always_comb begin
    e_new     = ram_rdata;
    cnt_inc   = (ram_rdata.cnt == 16'hFFFF) ? ram_rdata.cnt : ram_rdata.cnt + 16'd1;
    mbit      = 1'(mask >> proc_idx);
    e_match   = 1'b0;
    e_expired = 1'b0;
    e_remove  = 1'b0;
    e_hit     = (ram_rdata.evt == ev) && !found;
    case (act)
      ACT_TICK: begin
        e_match   = ram_rdata.cls == cls;
        e_expired = e_match && (cnt_inc >= ram_rdata.ival);
        e_remove  = e_expired && ((ram_rdata.mode == MODE_ONCE) ||
                                  ((ram_rdata.mode == MODE_COND) && mbit));
        if (e_match) begin
          e_new.cnt = e_expired ? 16'd0 : cnt_inc;
        end
      end
      ACT_DEL_TYPE:  e_remove = ram_rdata.typ == typ;
      ACT_DEL_MODE:  e_remove = ram_rdata.mode == mode;
      ACT_DEL_EVENT: e_remove = ram_rdata.evt == ev;
      ACT_RST_COUNT: e_new.cnt = 16'd0;
      default: ;
    endcase
    e_fire = walk_step && pend && e_expired && (k < ResCountW'(MaxResults));
  end

  assign ins_ok = (act == ACT_INSERT) && (st == ST_OK) && !found &&
                  (n < CW'(NUM_TIMERS));

  always_comb begin
    if (st != ST_OK) begin
      fin_status = st;
    end else begin
      case (act)
        ACT_INSERT:    fin_status = found ? ST_EXISTS :
                                    ((n >= CW'(NUM_TIMERS)) ? ST_FULL : ST_OK);
        ACT_RST_COUNT: fin_status = found ? ST_OK : ST_NOTFOUND;
        default:       fin_status = ST_OK;
      endcase
    end
  end

  // memory port steering: walk reads ahead, writes go back to already-read slots
  always_comb begin
    ram_re    = walk_step && (rd_idx < n);
    ram_raddr = rd_idx[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = w_idx[AW-1:0];
    ram_wdata = e_new;
    if (walk_step && pend) begin
      if (compacting) begin
        ram_we = !e_remove;
      end else if (act == ACT_RST_COUNT) begin
        ram_we    = e_hit;
        ram_waddr = proc_idx;
      end
    end
    if (fin_step && ins_ok) begin
      ram_we    = 1'b1;
      ram_waddr = n[AW-1:0];
      ram_wdata = '{evt: ev, mode: mode, typ: typ, cls: cls, ival: ival, cnt: start};
    end
  end

  // output loading: push the held fire when a newer one arrives, close at the end
  always_comb begin
    out_load      = 1'b0;
    out_load_data = '0;
    out_load_last = 1'b0;
    if (e_fire && held_valid) begin
      out_load      = 1'b1;
      out_load_data = {3'b0, held_event, 1'b1, 1'b0, ST_OK};
    end
    if (fin_step) begin
      out_load      = 1'b1;
      out_load_last = 1'b1;
      if (held_valid) begin
        out_load_data = {3'b0, held_event, 1'b1, 1'b0, ST_OK};
      end else begin
        out_load_data = {3'b0, 8'd0, 1'b0,
                         (act == ACT_QUERY) && (st == ST_OK) && found, fin_status};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_count <= '0;
      out_valid    <= 1'b0;
      pend         <= 1'b0;
      held_valid   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state      <= in_bad ? S_FIN : S_WALK;
            st         <= in_bad ? ST_INVALID : ST_OK;
            n          <= active_count;
            rd_idx     <= '0;
            w_idx      <= '0;
            pend       <= 1'b0;
            found      <= 1'b0;
            k          <= '0;
            held_valid <= 1'b0;
          end
        end
        S_WALK: begin
          if (!stall) begin
            if (walk_done) begin
              state <= S_FIN;
              if (compacting) begin
                active_count <= w_idx;
              end
            end else begin
              pend     <= ram_re;
              proc_idx <= rd_idx[AW-1:0];
              if (ram_re) begin
                rd_idx <= rd_idx + 1'b1;
              end
              if (pend) begin
                if (compacting && !e_remove) begin
                  w_idx <= w_idx + 1'b1;
                end
                if (e_hit) begin
                  found <= 1'b1;
                end
                if (e_fire) begin
                  held_valid <= 1'b1;
                  held_event <= ram_rdata.evt;
                  k          <= k + 1'b1;
                end
              end
            end
          end
        end
        S_FIN: begin
          if (!stall) begin
            state <= S_IDLE;
            if (ins_ok) begin
              active_count <= active_count + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (s_tvalid && s_tready) begin
      act   <= s_tuser;
      ev    <= in_ev;
      mode  <= in_mode;
      typ   <= in_typ;
      cls   <= in_cls;
      ival  <= in_ival;
      start <= in_start;
      mask  <= s_tdata[66:51];
    end
    if (out_load) begin
      out_data <= out_load_data;
      out_last <= out_load_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

endmodule

FILE: hdl/stt_checker.sv
module stt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);
  import stt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken during a walk");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[4] |-> m_tlast)
    else $error("status result not marked last");

  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> (m_tdata[2:0] == ST_OK) && !m_tdata[3])
    else $error("fired result carries a status or query answer");

endmodule

bind software_timer_table stt_checker u_stt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
